@@ sv/lli_pkg.sv @@
// Shared types and constants for the LED link indicator.
// Used by lli_ctrl, lli_dp and led_link_indicator_unit; no dependencies.
package lli_pkg;

  // Widths fixed by the stream and register formats
  localparam int unsigned NOW_W    = 32;   // now_ms field on the stream
  localparam int unsigned CFG_W    = 16;   // interval / period registers
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned PROD_W   = 24;   // 510 * (period/2) fits in 24 bits
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned S_DATA_W = 40;   // new_mode + now_ms, padded to bytes

  localparam int unsigned TIME_BITS_DEF = 32;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_OFF       = 2'd0;
  localparam mode_t MODE_PAIRING   = 2'd1;
  localparam mode_t MODE_CONNECTED = 2'd2;
  localparam mode_t MODE_RSVD      = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MODE = 1'b1;

  localparam logic [0:0] REG_BLINK  = 1'b0;
  localparam logic [0:0] REG_PERIOD = 1'b1;

  localparam logic [CFG_W-1:0]  BLINK_RST  = 16'd200;
  localparam logic [CFG_W-1:0]  PERIOD_RST = 16'd2000;
  localparam logic [DUTY_W-1:0] DUTY_DARK  = 8'hFF;
  localparam logic [DUTY_W-1:0] DUTY_LIT   = 8'h00;
  localparam logic [8:0]        LEVEL_SCALE = 9'd510;  // 2 * 255

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PHASE,
    ST_LVL_START,
    ST_LEVEL,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;         // latch accepted word
    logic mode_wr;      // store mode, clear flag, stamp time
    logic toggle;       // flip flag, stamp time, set blink duty
    logic duty_dark;
    logic phase_start;  // now mod period
    logic mul;          // d * 510
    logic level_start;  // (d * 510) / period
    logic duty_level;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic  item_op;
    mode_t item_mode;
    mode_t mode;
    logic  elapsed_ge;
    logic  div_done;
    logic  out_busy;
  } dp_sts_t;

endpackage

@@ sv/lli_ctrl.sv @@
// Sequencing FSM for the LED link indicator.
// Depends on lli_pkg; drives lli_dp through dp_cmd_t, reads dp_sts_t.
module lli_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lli_pkg::dp_sts_t sts_i,
  output lli_pkg::dp_cmd_t cmd_o
);
  import lli_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        if (sts_i.item_op == OP_MODE) begin
          if (sts_i.item_mode != MODE_RSVD) begin
            cmd_o.mode_wr = 1'b1;
            if (sts_i.item_mode == MODE_OFF) begin
              cmd_o.duty_dark = 1'b1;
              state_d         = ST_EMIT;
            end
          end
        end else begin
          unique case (sts_i.mode)
            MODE_OFF: begin
              cmd_o.duty_dark = 1'b1;
              state_d         = ST_EMIT;
            end
            MODE_PAIRING: begin
              if (sts_i.elapsed_ge) begin
                cmd_o.toggle = 1'b1;
                state_d      = ST_EMIT;
              end
            end
            MODE_CONNECTED: begin
              cmd_o.phase_start = 1'b1;
              state_d           = ST_PHASE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PHASE: begin
        if (sts_i.div_done) begin
          cmd_o.mul = 1'b1;
          state_d   = ST_LVL_START;
        end
      end
      ST_LVL_START: begin
        cmd_o.level_start = 1'b1;
        state_d           = ST_LEVEL;
      end
      ST_LEVEL: begin
        if (sts_i.div_done) begin
          cmd_o.duty_level = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ sv/lli_dp.sv @@
// Datapath: indicator state, shared restoring divider, scale multiply, output register.
// Depends on lli_pkg; commanded by lli_ctrl.
module lli_dp #(
  parameter int unsigned TIME_BITS = lli_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lli_pkg::dp_cmd_t            cmd_i,
  output lli_pkg::dp_sts_t            sts_o,
  input  logic                        in_op_i,
  input  lli_pkg::mode_t              in_mode_i,
  input  logic [lli_pkg::NOW_W-1:0]   in_now_i,
  input  logic [lli_pkg::CFG_W-1:0]   blink_interval_i,
  input  logic [lli_pkg::CFG_W-1:0]   breathing_period_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [lli_pkg::DUTY_W-1:0]  out_duty_o
);
  import lli_pkg::*;

  localparam int unsigned DIV_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  // latched word
  logic                 item_op_q;
  mode_t                item_mode_q;
  logic [TIME_BITS-1:0] item_now_q;

  // indicator state
  mode_t                mode_q;
  logic                 blink_q;
  logic [TIME_BITS-1:0] last_q;

  // divider / arithmetic
  logic [CNT_W-1:0]  cnt_q;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [CFG_W:0]    rem_shift;
  logic [CFG_W-1:0]  period;
  logic [CFG_W-1:0]  tri_d;
  logic [PROD_W-1:0] prod_q;
  logic [DUTY_W-1:0] duty_q;

  logic                 out_valid_q;
  logic [DUTY_W-1:0]    out_duty_q;
  logic [TIME_BITS-1:0] elapsed;

  // zero period behaves as one
  assign period  = (breathing_period_i == '0) ? CFG_W'(1) : breathing_period_i;
  assign elapsed = item_now_q - last_q;

  // one restoring step per cycle, dividend shifts out of quo_q as quotient shifts in
  always_comb begin
    rem_shift = {rem_q, quo_q[DIV_W-1]};
    if (rem_shift >= {1'b0, period}) begin
      rem_d = CFG_W'(rem_shift - {1'b0, period});
      quo_d = {quo_q[DIV_W-2:0], 1'b1};
    end else begin
      rem_d = rem_shift[CFG_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], 1'b0};
    end
  end

  // triangle distance from phase (rem_q after the first division)
  always_comb begin
    if ({rem_q, 1'b0} < {1'b0, period}) begin
      tri_d = rem_q;
    end else begin
      tri_d = period - rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PAIRING;
      blink_q     <= 1'b0;
      last_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mode_wr) begin
        mode_q  <= item_mode_q;
        blink_q <= 1'b0;
        last_q  <= item_now_q;
      end else if (cmd_i.toggle) begin
        blink_q <= !blink_q;
        last_q  <= item_now_q;
      end
      if (cmd_i.phase_start || cmd_i.level_start) begin
        cnt_q <= CNT_W'(DIV_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_op_q   <= in_op_i;
      item_mode_q <= in_mode_i;
      item_now_q  <= TIME_BITS'(in_now_i);
    end
    if (cmd_i.phase_start) begin
      rem_q <= '0;
      quo_q <= DIV_W'(item_now_q);
    end else if (cmd_i.level_start) begin
      rem_q <= '0;
      quo_q <= DIV_W'(prod_q);
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(tri_d) * PROD_W'(LEVEL_SCALE);
    end
    if (cmd_i.duty_dark) begin
      duty_q <= DUTY_DARK;
    end else if (cmd_i.toggle) begin
      duty_q <= blink_q ? DUTY_DARK : DUTY_LIT;  // flag about to set -> lit
    end else if (cmd_i.duty_level) begin
      duty_q <= DUTY_DARK - quo_q[DUTY_W-1:0];
    end
    if (cmd_i.emit) begin
      out_duty_q <= duty_q;
    end
  end

  assign sts_o.item_op    = item_op_q;
  assign sts_o.item_mode  = item_mode_q;
  assign sts_o.mode       = mode_q;
  assign sts_o.elapsed_ge = elapsed >= TIME_BITS'(blink_interval_i);
  assign sts_o.div_done   = (cnt_q == '0);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_duty_o  = out_duty_q;

  // divider is never restarted mid-run
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.phase_start || cmd_i.level_start) |-> cnt_q == '0)
    else $error("divider restarted while busy");

  // a pending word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten");

  // triangle level quotient never exceeds 255
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.duty_level |-> quo_q[DIV_W-1:DUTY_W] == '0)
    else $error("level out of range");

  // stored mode never takes the reserved code
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_RSVD)
    else $error("reserved mode stored");

endmodule

@@ sv/led_link_indicator_unit.sv @@
// Sequence: a mode change is latched, then stored (a change to off also emits dark); an off or
//   pairing tick is latched, decided and emitted to the output register; a connected tick runs
//   the shared one-bit-per-cycle restoring divider twice (phase, then level) before the emit.
// Throughput: one word at a time; s_tready is high only while the sequencer is idle,
//   and a finished result waits in the output register while the next word is taken.
// Reset (rst_ni, async low): pairing mode, flag clear, last toggle 0, interval 200,
//   period 2000, no result pending.
module led_link_indicator_unit #(
  parameter int unsigned TIME_BITS = lli_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lli_pkg::S_DATA_W-1:0]  s_tdata,  // [1:0] new_mode, [33:2] now_ms, rest 0
  input  logic [0:0]                    s_tuser,  // [0] operation (0 tick, 1 mode change)
  // result words
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lli_pkg::DUTY_W-1:0]    m_tdata,  // [7:0] pwm_duty
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lli_pkg::APB_AW-1:0]    paddr,
  input  logic [lli_pkg::APB_DW-1:0]    pwdata,
  output logic [lli_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import lli_pkg::*;

  logic [CFG_W-1:0] blink_q, period_q;
  logic             wr_en;
  logic [0:0]       reg_idx;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  // registers at byte address 4*i; address bits below the word are ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q  <= BLINK_RST;
      period_q <= PERIOD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BLINK:  blink_q  <= pwdata[CFG_W-1:0];
        REG_PERIOD: period_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLINK:  prdata = APB_DW'(blink_q);
      REG_PERIOD: prdata = APB_DW'(period_q);
      default:    prdata = '0;
    endcase
  end

  lli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lli_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_op_i            (s_tuser[0]),
    .in_mode_i          (s_tdata[1:0]),
    .in_now_i           (s_tdata[NOW_W+1:2]),
    .blink_interval_i   (blink_q),
    .breathing_period_i (period_q),
    .out_ready_i        (m_tready),
    .out_valid_o        (m_tvalid),
    .out_duty_o         (m_tdata)
  );

endmodule

@@ sim/led_link_indicator_unit_test.sv @@
// Self-checking testbench for led_link_indicator_unit: stream words in, duty words out,
// registers over APB. Expected duties come from a behavioral predictor kept in this file.
// Depends on lli_pkg and the RTL only.
`timescale 1ns / 100ps

module led_link_indicator_unit_test;
  import lli_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 100;     // margin for the slowest word (connected tick)
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_WORDS = 480;
  localparam int unsigned RANDOM_PHASES = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // [1:0] new_mode, [33:2] now_ms, rest 0
  logic [0:0]          s_tuser;   // [0] operation
  logic                m_tvalid;
  logic                m_tready = 1'b1;
  logic [DUTY_W-1:0]   m_tdata;   // [7:0] pwm_duty
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // idling controls, switched per phase
  bit gaps_on = 1'b1;
  bit backpressure_on = 1'b1;

  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  // predictor state: mirrors the block's mode, flag, stamp and registers
  mode_t             cur_mode;
  logic              blink_flag;
  logic [NOW_W-1:0]  toggle_stamp;
  logic [CFG_W-1:0]  blink_ivl;
  logic [CFG_W-1:0]  breath_period;
  logic [DUTY_W-1:0] pending_duty[$];

  led_link_indicator_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk_i = ~clk_i;

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Triangle brightness: level = 2*d*255/period, d = distance to the nearest
  // period boundary; a zero period acts as one. Duty is the inverted level.
  function automatic logic [DUTY_W-1:0] breathing_duty(logic [NOW_W-1:0] t_ms);
    longint unsigned per, phase, d, level;
    per = (breath_period == 0) ? 1 : breath_period;
    phase = t_ms % per;
    d = (2 * phase < per) ? phase : per - phase;
    level = (2 * d * 255) / per;
    if (level > 255) level = 255;
    return DUTY_DARK - level[DUTY_W-1:0];
  endfunction

  // Updates predictor state for one accepted word and queues its duty, if any.
  function automatic void predict_led_duty(logic op, mode_t md, logic [NOW_W-1:0] t_ms);
    logic [NOW_W-1:0] elapsed;
    if (op == OP_MODE) begin
      if (md == MODE_RSVD) return;   // reserved code: word is dropped
      cur_mode = md;
      blink_flag = 1'b0;
      toggle_stamp = t_ms;
      if (md == MODE_OFF) pending_duty.push_back(DUTY_DARK);
    end else if (cur_mode == MODE_OFF) begin
      pending_duty.push_back(DUTY_DARK);
    end else if (cur_mode == MODE_PAIRING) begin
      elapsed = t_ms - toggle_stamp;   // wraps modulo 2^32
      if (elapsed >= blink_ivl) begin
        toggle_stamp = t_ms;
        blink_flag = ~blink_flag;
        pending_duty.push_back(blink_flag ? DUTY_LIT : DUTY_DARK);
      end
    end else begin
      pending_duty.push_back(breathing_duty(t_ms));
    end
  endfunction

  // All driving tasks start right after a falling edge and return right after one.
  task automatic send_word(logic op, mode_t md, logic [NOW_W-1:0] t_ms);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 25) begin
        s_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = '0;
    s_tdata[1:0] = md;
    s_tdata[33:2] = t_ms;
    do @(posedge clk_i); while (!s_tready);
    predict_led_duty(op, md, t_ms);
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  task automatic apb_write(logic [0:0] reg_idx, logic [CFG_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_idx, 2'b00};
    pwdata = {16'($urandom), value};   // upper bits are don't-care
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_BLINK) blink_ivl = value;
    else breath_period = value;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read_check(logic [0:0] reg_idx);
    logic [CFG_W-1:0] want;
    want = (reg_idx == REG_BLINK) ? blink_ivl : breath_period;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {reg_idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== want)
      flag_error($sformatf("register %0d readback: expected %0d, got %0d",
                           reg_idx, want, prdata[CFG_W-1:0]));
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Registers only change once every expected duty is out and the block had
  // time to finish a word that yields no duty.
  task automatic wait_drained();
    while (pending_duty.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_registers(logic [CFG_W-1:0] ivl, logic [CFG_W-1:0] per);
    wait_drained();
    apb_write(REG_BLINK, ivl);
    apb_write(REG_PERIOD, per);
    apb_read_check(REG_BLINK);
    apb_read_check(REG_PERIOD);
  endtask

  task automatic test_reset_values();
    apb_read_check(REG_BLINK);
    apb_read_check(REG_PERIOD);
  endtask

  // Default registers (200 / 2000), block comes up pairing with stamp 0.
  task automatic test_special_cases();
    send_word(OP_TICK, MODE_OFF, 32'd0);            // before interval: no duty
    send_word(OP_TICK, MODE_OFF, 32'd199);
    send_word(OP_TICK, MODE_OFF, 32'd200);          // toggle on -> lit
    send_word(OP_TICK, MODE_OFF, 32'd399);
    send_word(OP_TICK, MODE_OFF, 32'd400);          // toggle off -> dark
    send_word(OP_MODE, MODE_PAIRING, 32'hFFFF_FF00);
    send_word(OP_TICK, MODE_OFF, 32'h0000_0010);    // elapsed across the wrap
    send_word(OP_MODE, MODE_RSVD, 32'd5);           // reserved mode: dropped
    send_word(OP_TICK, MODE_RSVD, 32'h0000_0020);
    send_word(OP_MODE, MODE_OFF, 32'hFFFF_FFFF);    // off change emits dark
    send_word(OP_TICK, MODE_OFF, 32'd0);
    send_word(OP_TICK, MODE_RSVD, 32'h5555_AAAA);
    send_word(OP_MODE, MODE_CONNECTED, 32'd1234);
    send_word(OP_TICK, MODE_OFF, 32'd0);
    send_word(OP_TICK, MODE_OFF, 32'd500);
    send_word(OP_TICK, MODE_OFF, 32'd999);
    send_word(OP_TICK, MODE_OFF, 32'd1000);         // peak brightness
    send_word(OP_TICK, MODE_OFF, 32'd1001);
    send_word(OP_TICK, MODE_OFF, 32'd1999);
    send_word(OP_TICK, MODE_OFF, 32'hFFFF_FFFF);
    send_word(OP_TICK, MODE_PAIRING, 32'hAAAA_5555);
  endtask

  task automatic test_register_extremes();
    logic [NOW_W-1:0] t_ms;
    t_ms = $urandom;
    // zero interval toggles on every tick, zero period stays dark
    set_registers(16'd0, 16'd0);
    send_word(OP_MODE, MODE_PAIRING, t_ms);
    repeat (3) send_word(OP_TICK, MODE_OFF, t_ms);
    send_word(OP_MODE, MODE_CONNECTED, t_ms);
    send_word(OP_TICK, MODE_OFF, t_ms);
    send_word(OP_TICK, MODE_OFF, $urandom);
    // widest settings
    set_registers(16'hFFFF, 16'hFFFF);
    send_word(OP_MODE, MODE_PAIRING, 32'd0);
    send_word(OP_TICK, MODE_OFF, 32'd65534);
    send_word(OP_TICK, MODE_OFF, 32'd65535);
    send_word(OP_MODE, MODE_CONNECTED, 32'd0);
    send_word(OP_TICK, MODE_OFF, 32'd32767);
    send_word(OP_TICK, MODE_OFF, 32'd32768);
    send_word(OP_TICK, MODE_OFF, $urandom);
    // narrowest nonzero settings
    set_registers(16'd1, 16'd1);
    send_word(OP_TICK, MODE_OFF, 32'd7);
    set_registers(16'd1, 16'd2);
    send_word(OP_TICK, MODE_OFF, 32'd1);            // half period -> full level
    send_word(OP_TICK, MODE_OFF, 32'd2);
    send_word(OP_MODE, MODE_PAIRING, 32'd10);
    send_word(OP_TICK, MODE_OFF, 32'd10);
    send_word(OP_TICK, MODE_OFF, 32'd11);
  endtask

  // Mostly ordered time with mode changes mixed in; a few jumps anywhere in
  // the 32-bit range (including backwards) act as noise.
  task automatic test_random_traffic();
    logic [NOW_W-1:0] t_ms;
    logic             op;
    mode_t            md;
    int unsigned      sent;
    logic [CFG_W-1:0] ivl, per;
    t_ms = $urandom;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin ivl = 16'd1; per = 16'd1; end
        1: begin ivl = 16'hFFFF; per = 16'hFFFF; end
        default: begin
          ivl = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 65535))
                                            : CFG_W'($urandom_range(1, 400));
          per = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 65535))
                                            : CFG_W'($urandom_range(2, 5000));
        end
      endcase
      set_registers(ivl, per);
      // phases 2 and 3 run with no idling on either side
      gaps_on = !(phase == 2 || phase == 3);
      backpressure_on = gaps_on;
      sent = 0;
      while (sent < RANDOM_WORDS / RANDOM_PHASES) begin
        if ($urandom_range(0, 99) < 12) begin
          op = OP_MODE;
          md = ($urandom_range(0, 99) < 8) ? MODE_RSVD : mode_t'($urandom_range(0, 2));
        end else begin
          op = OP_TICK;
          md = mode_t'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 99) < 6) t_ms = $urandom;
        else t_ms = t_ms + $urandom_range(0, 2 * int'(blink_ivl) + 2);
        send_word(op, md, t_ms);
        if (!(op == OP_MODE && md == MODE_RSVD)) sent++;
      end
    end
    gaps_on = 1'b1;
    backpressure_on = 1'b1;
  endtask

  // Result side: random stalls, changed at the falling edge only.
  always @(negedge clk_i)
    m_tready <= backpressure_on ? ($urandom_range(0, 99) >= 25) : 1'b1;

  // Each accepted duty word against the oldest expectation.
  always @(posedge clk_i) begin
    logic [DUTY_W-1:0] want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_duty.size() == 0) begin
        flag_error($sformatf("unexpected duty word %0d", m_tdata));
      end else begin
        want = pending_duty.pop_front();
        if (m_tdata !== want)
          flag_error($sformatf("pwm_duty: expected %0d, got %0d", want, m_tdata));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_TICK;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_mode = MODE_PAIRING;
    blink_flag = 1'b0;
    toggle_stamp = '0;
    blink_ivl = BLINK_RST;
    breath_period = PERIOD_RST;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_special_cases();
    test_register_extremes();
    test_random_traffic();

    wait_drained();
    errors += pending_duty.size();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
